[rtl/pdop_pkg.sv]
package pdop_pkg;

   // Fixed-point format of the coordinates
   localparam int COORD_FRAC_BITS = 8;

   // Defaults for the top-level parameters
   localparam int MAX_PARTICLES_DEF = 256;

   // Box edge after reset: 100.0 in Q8.8
   localparam logic [15:0] BOX_RESET = 16'd25600;

   // Minimum allowed squared distance: 4.0 with 2*COORD_FRAC_BITS fraction bits
   localparam logic [32:0] DIST_LIMIT = 33'd4 << (2 * COORD_FRAC_BITS);

   // Operation codes (req_tuser)
   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_PLACE = 1'b1;

   // Result status codes
   localparam logic [2:0] STATUS_PLACED     = 3'd0;
   localparam logic [2:0] STATUS_OVERLAP    = 3'd1;
   localparam logic [2:0] STATUS_FULL       = 3'd2;
   localparam logic [2:0] STATUS_CLEARED    = 3'd3;
   localparam logic [2:0] STATUS_OUT_OF_BOX = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Status of the distance pipeline toward the controller
   typedef struct packed {
      logic busy;   // some stage holds a valid entry
      logic hit;    // an entry closer than the limit leaves the pipeline
   } dist_stat_type;

endpackage

[rtl/periodic_disk_overlap_placer.sv]
// Periodic disk overlap placer: keeps the centres of placed disks in a
// periodic square box and accepts a candidate only if no stored centre lies
// closer than 2.0 under the minimum-image convention.
// req channel: tuser[0] is the operation (clear or place), tdata carries the
// candidate position. rsp channel: one transfer per request with the status
// and the number of stored centres after the request.
// csr_wen/csr_wdata write the box edge length; write it only while idle.
// One request is handled at a time. Clear, out-of-box, full and the first
// placement need no scan. Otherwise the stored centres are read from the
// table one per cycle into a 4-stage distance pipeline; the scan stops
// early on the first overlap.
// The result sits in an output register; while rsp_tready is low the block
// holds the result and accepts no further request once the next one is done.
// Reset empties the table (count to 0), restores the box edge to 100.0 and
// drops any pending result. Table contents are not cleared.
module periodic_disk_overlap_placer #(
   parameter int MAX_PARTICLES = pdop_pkg::MAX_PARTICLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] pos_x, [31:16] pos_y
   input  logic [0:0]  req_tuser,    // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [2:0] status, [11:3] placed_count, [15:12] zero
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata     // box edge
);

   localparam int ADDR_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

   pdop_pkg::state_type state_ff, state_in;

   logic [15:0]      box_ff, box_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             scan_hit_ff, scan_hit_in;
   logic [2:0]       status_ff, status_in;
   logic [15:0]      cand_x_ff, cand_x_in;
   logic [15:0]      cand_y_ff, cand_y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;

   logic             issue;
   logic             mem_wr_en;
   logic [31:0]      mem_rd_data;
   logic [8:0]       count_out;
   pdop_pkg::dist_stat_type dist_stat;

   pdop_centre_mem #(
      .DEPTH  (MAX_PARTICLES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({cand_x_ff, cand_y_ff}),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   pdop_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rd_vld_ff),
      .entry_data (mem_rd_data),
      .cand_x     (cand_x_ff),
      .cand_y     (cand_y_ff),
      .box_edge   (box_ff),
      .stat       (dist_stat)
   );

   // placed_count is the updated stored count truncated or zero-extended to 9 bits
   generate
      if (CNT_W >= 9) begin : g_cnt_trunc
         assign count_out = count_in[8:0];
      end else begin : g_cnt_ext
         assign count_out = {{(9 - CNT_W){1'b0}}, count_in};
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      box_in       = csr_wen ? csr_wdata : box_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      scan_hit_in  = scan_hit_ff;
      status_in    = status_ff;
      cand_x_in    = cand_x_ff;
      cand_y_in    = cand_y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      issue        = 1'b0;
      mem_wr_en    = 1'b0;

      unique case (state_ff)
         pdop_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cand_x_in = req_tdata[15:0];
               cand_y_in = req_tdata[31:16];
               state_in  = pdop_pkg::ST_DONE;
               if (req_tuser[0] == pdop_pkg::OP_CLEAR) begin
                  status_in = pdop_pkg::STATUS_CLEARED;
               end else if (req_tdata[15:0] >= box_ff || req_tdata[31:16] >= box_ff) begin
                  status_in = pdop_pkg::STATUS_OUT_OF_BOX;
               end else if (count_ff == CNT_MAX) begin
                  status_in = pdop_pkg::STATUS_FULL;
               end else if (count_ff == '0) begin
                  status_in = pdop_pkg::STATUS_PLACED;
               end else begin
                  rd_idx_in   = '0;
                  scan_hit_in = 1'b0;
                  state_in    = pdop_pkg::ST_SCAN;
               end
            end
         end
         pdop_pkg::ST_SCAN: begin
            issue       = (rd_idx_ff < count_ff) && !scan_hit_ff;
            scan_hit_in = scan_hit_ff | dist_stat.hit;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            // all reads done and the pipeline drained: hit flag is final
            if (!issue && !rd_vld_ff && !dist_stat.busy) begin
               status_in = scan_hit_ff ? pdop_pkg::STATUS_OVERLAP
                                       : pdop_pkg::STATUS_PLACED;
               state_in  = pdop_pkg::ST_DONE;
            end
         end
         pdop_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               case (status_ff)
                  pdop_pkg::STATUS_PLACED: begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
                  pdop_pkg::STATUS_CLEARED: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, count_out, status_ff};
               state_in     = pdop_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdop_pkg::ST_IDLE;
         end
      endcase
      rd_vld_in = issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdop_pkg::ST_IDLE;
         box_ff       <= pdop_pkg::BOX_RESET;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         scan_hit_ff  <= 1'b0;
         status_ff    <= pdop_pkg::STATUS_PLACED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_ff       <= box_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         scan_hit_ff  <= scan_hit_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_x_ff   <= cand_x_in;
      cand_y_ff   <= cand_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/pdop_centre_mem.sv]
module pdop_centre_mem #(
   parameter int DEPTH  = pdop_pkg::MAX_PARTICLES_DEF,
   parameter int ADDR_W = $clog2(pdop_pkg::MAX_PARTICLES_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,   // x in [31:16], y in [15:0]
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] table_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pdop_dist.sv]
module pdop_dist (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [31:0]             entry_data,   // x in [31:16], y in [15:0]
   input  logic [15:0]             cand_x,
   input  logic [15:0]             cand_y,
   input  logic [15:0]             box_edge,
   output pdop_pkg::dist_stat_type stat
);

   // Minimum-image magnitude of one axis difference
   function automatic logic [15:0] wrap_mag(input logic signed [16:0] d,
                                            input logic [15:0] box);
      logic signed [17:0] de;
      logic signed [17:0] bx;
      logic signed [17:0] tw;
      logic signed [17:0] w;
      de = {d[16], d};
      bx = signed'({2'b00, box});
      tw = {d, 1'b0};
      if (tw > bx) begin
         w = de - bx;
      end else if (tw < -bx) begin
         w = de + bx;
      end else begin
         w = de;
      end
      if (w < 0) begin
         w = -w;
      end
      return w[15:0];
   endfunction

   // stage A: raw differences
   logic               va_ff, va_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   // stage B: wrapped magnitudes
   logic               vb_ff, vb_in;
   logic [15:0]        mx_ff, mx_in, my_ff, my_in;
   // stage C: squares
   logic               vc_ff, vc_in;
   logic [31:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   // stage D: compare against the limit
   logic               vd_ff, vd_in;
   logic               close_ff, close_in;

   always_comb begin
      va_in    = in_valid;
      dx_in    = signed'({1'b0, entry_data[31:16]}) - signed'({1'b0, cand_x});
      dy_in    = signed'({1'b0, entry_data[15:0]})  - signed'({1'b0, cand_y});
      vb_in    = va_ff;
      mx_in    = wrap_mag(dx_ff, box_edge);
      my_in    = wrap_mag(dy_ff, box_edge);
      vc_in    = vb_ff;
      sqx_in   = mx_ff * mx_ff;
      sqy_in   = my_ff * my_ff;
      vd_in    = vc_ff;
      close_in = ({1'b0, sqx_ff} + {1'b0, sqy_ff}) < pdop_pkg::DIST_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
         vd_ff <= vd_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      close_ff <= close_in;
   end

   assign stat.busy = va_ff | vb_ff | vc_ff | vd_ff;
   assign stat.hit  = vd_ff & close_ff;

endmodule
